// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the RTL of the reduction core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge, held off while reset is asserted.
`define DRP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("drp assertion failed");
// Checked on every rising edge, also during reset.
`define DRP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("drp assertion failed");
`else
`define DRP_ASSERT(lbl, clk, rstn, prop)
`define DRP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/core/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg
// Types, constants and the character map of the digest-to-password reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IterW   = 32;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned BinW    = 16;
  localparam int unsigned PosW    = 7;
  localparam int unsigned SumW    = IterW + 1;
  localparam int unsigned ResW    = 7;
  localparam int unsigned StepW   = 2;
  localparam int unsigned FoldW   = 12;  // 4096 = 1 (mod 65)
  localparam int unsigned LoW     = 6;   // 64 = -1 (mod 65)

  localparam logic [ResW-1:0]   ReduceMod = 7'd65;
  localparam logic [ResW-1:0]   SkipValue = 7'd64;
  localparam logic [StepW-1:0]  NumSteps  = 2'd3;

  localparam logic [CodeW-1:0] ChDigit0 = 7'h30;  // '0'
  localparam logic [CodeW-1:0] ChUpperA = 7'h41;  // 'A'
  localparam logic [CodeW-1:0] ChLowerA = 7'h61;  // 'a'
  localparam logic [CodeW-1:0] ChDash   = 7'h2D;  // '-'
  localparam logic [CodeW-1:0] ChUnder  = 7'h5F;  // '_'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_HOLD
  } drp_state_e;

  typedef struct packed {
    logic            done;
    logic [ResW-1:0] residue;
  } drp_mod_res_t;

  // Map a residue 0..63 onto 0-9, A-Z, a-z, '-', '_'
  function automatic logic [CodeW-1:0] code_of(input logic [ResW-1:0] v);
    logic [CodeW-1:0] c;
    if (v < 7'd10) begin
      c = ChDigit0 + v;
    end else if (v < 7'd36) begin
      c = ChUpperA + (v - 7'd10);
    end else if (v < 7'd62) begin
      c = ChLowerA + (v - 7'd36);
    end else if (v == 7'd62) begin
      c = ChDash;
    end else begin
      c = ChUnder;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/drp_in_if.sv
// ----------------------------------------------------------------------------
// drp_in_if
// Input channel: one digest byte per item, with iteration and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface drp_in_if;
  logic                             valid;
  logic                             ready;
  logic [drp_pkg::ByteW-1:0]        digest_byte;
  logic [drp_pkg::IterW-1:0]        iteration;
  logic                             last_byte;

  modport source (output valid, output digest_byte, output iteration,
                  output last_byte, input ready);
  modport sink   (input valid, input digest_byte, input iteration,
                  input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/drp_out_if.sv
// ----------------------------------------------------------------------------
// drp_out_if
// Output channel: one password character per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface drp_out_if;
  logic                             valid;
  logic                             ready;
  logic [drp_pkg::CodeW-1:0]        char_code;
  logic                             kept;
  logic                             last_char;

  modport source (output valid, output char_code, output kept,
                  output last_char, input ready);
  modport sink   (input valid, input char_code, input kept,
                  input last_char, output ready);
endinterface

`default_nettype wire

// File: rtl/core/digest_reduce_to_password_core.sv
// ----------------------------------------------------------------------------
// digest_reduce_to_password_core
// Folds digest bytes into PASSWORD_LEN bins and emits one character per bin.
// ----------------------------------------------------------------------------
//  port    dir  item
//  in_i    in   digest_byte, iteration, last_byte
//  out_o   out  char_code, kept, last_char
//
//  A byte not flagged last is taken while idle; ready stays high.
//  A last byte starts emission: each bin goes through load, three steps of
//  the shared mod 65 unit, a wait to see it finish, and hand-off to the output
//  register. Input ready is low meanwhile.
//  A stalled output holds the sequencer in the hand-off state.
//  Reset clears bins, byte count and all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module digest_reduce_to_password_core #(
  parameter int unsigned PASSWORD_LEN     = 8,
  parameter int unsigned MAX_DIGEST_BYTES = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  drp_in_if.sink     in_i,
  drp_out_if.source  out_o
);

  localparam int unsigned IdxW = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;
  localparam logic [IdxW-1:0]              LastIdx = IdxW'(PASSWORD_LEN - 1);
  localparam logic [drp_pkg::PosW-1:0]     MaxPos  = drp_pkg::PosW'(MAX_DIGEST_BYTES);

  drp_pkg::drp_state_e              state_q, state_d;
  logic [drp_pkg::BinW-1:0]         bins_q [PASSWORD_LEN];
  logic [IdxW-1:0]                  idx_q, idx_d;
  logic [drp_pkg::PosW-1:0]         pos_q, pos_d;
  logic [drp_pkg::IterW-1:0]        iter_q, iter_d;
  logic                             out_valid_q, out_valid_d;
  logic [drp_pkg::CodeW-1:0]        char_q, char_d;
  logic                             kept_q, kept_d;
  logic                             lastc_q, lastc_d;

  logic                             in_acc;
  logic                             add_en;
  logic                             slot_free;
  logic                             mod_start;
  logic [drp_pkg::SumW-1:0]         mod_operand;
  drp_pkg::drp_mod_res_t            mod_res;
  logic [drp_pkg::BinW-1:0]         bin_rd;

  assign in_acc    = in_i.valid && in_i.ready;
  assign add_en    = in_acc && (pos_q < MaxPos);
  assign slot_free = !out_valid_q || out_o.ready;
  assign bin_rd    = bins_q[idx_q];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      drp_pkg::ST_IDLE: begin
        if (in_acc && in_i.last_byte) begin
          state_d = drp_pkg::ST_LOAD;
        end
      end
      drp_pkg::ST_LOAD: begin
        state_d = drp_pkg::ST_REDUCE;
      end
      drp_pkg::ST_REDUCE: begin
        if (mod_res.done) begin
          state_d = drp_pkg::ST_HOLD;
        end
      end
      drp_pkg::ST_HOLD: begin
        if (slot_free) begin
          state_d = (idx_q == LastIdx) ? drp_pkg::ST_IDLE : drp_pkg::ST_LOAD;
        end
      end
      default: state_d = drp_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_i.ready  = 1'b0;
    mod_start   = 1'b0;
    mod_operand = {{(drp_pkg::SumW - drp_pkg::BinW){1'b0}}, bin_rd} + {1'b0, iter_q};
    idx_d       = idx_q;
    pos_d       = pos_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && !out_o.ready;
    char_d      = char_q;
    kept_d      = kept_q;
    lastc_d     = lastc_q;
    case (state_q)
      drp_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (add_en) begin
          pos_d = pos_q + 1'b1;
          idx_d = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
        end
        if (in_acc && in_i.last_byte) begin
          iter_d = in_i.iteration;
          idx_d  = '0;
        end
      end
      drp_pkg::ST_LOAD: begin
        mod_start = 1'b1;
      end
      drp_pkg::ST_REDUCE: begin
      end
      drp_pkg::ST_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          lastc_d     = (idx_q == LastIdx);
          if (mod_res.residue == drp_pkg::SkipValue) begin
            char_d = '0;
            kept_d = 1'b0;
          end else begin
            char_d = drp_pkg::code_of(mod_res.residue);
            kept_d = 1'b1;
          end
          if (idx_q == LastIdx) begin
            idx_d = '0;
            pos_d = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  drp_mod65 u_mod65 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .operand_i (mod_operand),
    .res_o     (mod_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drp_pkg::ST_IDLE;
      idx_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // bins: accumulate while idle, cleared as each one is read out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PASSWORD_LEN; i++) begin
        bins_q[i] <= '0;
      end
    end else if (add_en) begin
      bins_q[idx_q] <= bin_rd + drp_pkg::BinW'(in_i.digest_byte);
    end else if (state_q == drp_pkg::ST_LOAD) begin
      bins_q[idx_q] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q  <= iter_d;
    char_q  <= char_d;
    kept_q  <= kept_d;
    lastc_q <= lastc_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.kept      = kept_q;
  assign out_o.last_char = lastc_q;

  `DRP_ASSERT(a_done_in_reduce, clk_i, rst_ni, mod_res.done |-> state_q == drp_pkg::ST_REDUCE)
  `DRP_ASSERT(a_pos_bounded, clk_i, rst_ni, pos_q <= MaxPos)
  `DRP_ASSERT(a_back_to_idle_clean, clk_i, rst_ni,
    (state_q == drp_pkg::ST_IDLE && $past(state_q) == drp_pkg::ST_HOLD) |-> (pos_q == '0 && idx_q == '0))
  `DRP_ASSERT(a_skip_code_zero, clk_i, rst_ni, (out_valid_q && !kept_q) |-> char_q == '0)
  `DRP_ASSERT_ALWAYS(a_reset_no_output, clk_i, !rst_ni |-> !out_valid_q)

endmodule

`default_nettype wire

// File: rtl/core/drp_mod65.sv
// ----------------------------------------------------------------------------
// drp_mod65
// Reduction of a 33-bit value modulo 65: two 12-bit folds and a correction.
// ----------------------------------------------------------------------------
`default_nettype none

module drp_mod65 (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [drp_pkg::SumW-1:0]     operand_i,
  output drp_pkg::drp_mod_res_t             res_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [drp_pkg::StepW-1:0]     cnt_q, cnt_d;
  logic [drp_pkg::SumW-1:0]      acc_q, acc_d;
  logic [drp_pkg::ResW-1:0]      rem_q, rem_d;
  logic [drp_pkg::SumW-1:0]      fold;
  logic [drp_pkg::ResW:0]        corr;

  always_comb begin
    // sum of the 12-bit slices (the top slice is 9 bits)
    fold = drp_pkg::SumW'(acc_q[drp_pkg::FoldW-1:0])
         + drp_pkg::SumW'(acc_q[2*drp_pkg::FoldW-1:drp_pkg::FoldW])
         + drp_pkg::SumW'(acc_q[drp_pkg::SumW-1:2*drp_pkg::FoldW]);
    // low six bits minus the rest, offset by 65
    corr = {2'b00, acc_q[drp_pkg::LoW-1:0]} + {1'b0, drp_pkg::ReduceMod}
         - {1'b0, acc_q[drp_pkg::LoW+drp_pkg::ResW-1:drp_pkg::LoW]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = drp_pkg::NumSteps;
      acc_d  = operand_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == drp_pkg::StepW'(1)) begin
        if (corr >= {1'b0, drp_pkg::ReduceMod}) begin
          rem_d = drp_pkg::ResW'(corr - {1'b0, drp_pkg::ReduceMod});
        end else begin
          rem_d = drp_pkg::ResW'(corr);
        end
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        acc_d = fold;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign res_o.done    = done_q;
  assign res_o.residue = rem_q;

endmodule

`default_nettype wire
